// ----- rtl/core/mpct_pkg.sv -----
// Shared types and constants for the mouse packet cursor tracker.
`timescale 1ns / 1ps

package mpct_pkg;

    localparam int MPCT_QUEUE_DEPTH = 2;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [12:0] SCREEN_WIDTH_RST = 13'd1024;
    localparam logic [12:0] SCREEN_HEIGHT_RST = 13'd768;
    localparam logic [8:0] CURSOR_WIDTH_RST = 9'd16;
    localparam logic [8:0] CURSOR_HEIGHT_RST = 9'd16;

    // Sync bit of the first packet byte.
    localparam int SYNC_BIT = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCREEN_WIDTH = 2'd0,
        CFG_SCREEN_HEIGHT = 2'd1,
        CFG_CURSOR_WIDTH = 2'd2,
        CFG_CURSOR_HEIGHT = 2'd3
    } t_cfg_index;

    typedef enum logic [2:0] {
        EV_LPRESS = 3'd0,
        EV_RPRESS = 3'd1,
        EV_LRELEASE = 3'd2,
        EV_RRELEASE = 3'd3,
        EV_MOVE = 3'd4,
        EV_OTHER = 3'd5
    } t_event;

    typedef enum logic [1:0] {
        FR_FIRST = 2'd0,
        FR_SECOND = 2'd1,
        FR_THIRD = 2'd2
    } t_frame_state;

    typedef struct packed {
        logic [12:0] screen_width;
        logic [12:0] screen_height;
        logic [8:0] cursor_width;
        logic [8:0] cursor_height;
    } t_cfg;

    typedef struct packed {
        logic [7:0] first_byte;
        logic signed [8:0] delta_x;
        logic signed [8:0] delta_y;
    } t_packet;

endpackage

// ----- rtl/core/mpct_front.sv -----
// Byte framer: collects three-byte packets and extends the deltas.
`timescale 1ns / 1ps

module mpct_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic [7:0]             i_byte,
    output logic                   o_ready,
    output logic                   o_pkt_valid,
    output mpct_pkg::t_packet      o_pkt,
    input  logic                   i_pkt_ready
);
    import mpct_pkg::*;

    t_frame_state r_state, n_state;
    logic [7:0] r_first_byte, n_first_byte;
    logic signed [8:0] r_delta_x, n_delta_x;
    logic accept;

    assign o_ready = i_pkt_ready;
    assign accept = i_valid && i_pkt_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        if (accept) begin
            case (r_state)
                FR_SECOND: n_state = FR_THIRD;
                FR_THIRD: n_state = FR_FIRST;
                default: n_state = i_byte[SYNC_BIT] ? FR_SECOND : FR_FIRST;
            endcase
        end
    end

    // Outputs and captured bytes
    always_comb begin
        n_first_byte = r_first_byte;
        n_delta_x = r_delta_x;
        o_pkt_valid = 1'b0;
        case (r_state)
            FR_SECOND: begin
                if (accept) n_delta_x = {r_first_byte[4], i_byte};
            end
            FR_THIRD: begin
                o_pkt_valid = i_valid;
            end
            default: begin
                if (accept && i_byte[SYNC_BIT]) n_first_byte = i_byte;
            end
        endcase
        o_pkt.first_byte = r_first_byte;
        o_pkt.delta_x = r_delta_x;
        o_pkt.delta_y = {r_first_byte[5], i_byte};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FR_FIRST;
            r_first_byte <= '0;
            r_delta_x <= '0;
        end else begin
            r_state <= n_state;
            r_first_byte <= n_first_byte;
            r_delta_x <= n_delta_x;
        end
    end

endmodule

// ----- rtl/core/mpct_queue.sv -----
// Short packet queue between the framer and the cursor tracker.
`timescale 1ns / 1ps

module mpct_queue #(
    parameter int DEPTH = mpct_pkg::MPCT_QUEUE_DEPTH  // at least 2
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  mpct_pkg::t_packet      i_pkt,
    output logic                   o_ready,
    output logic                   o_valid,
    output mpct_pkg::t_packet      o_pkt,
    input  logic                   i_ready
);
    import mpct_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

    t_packet r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic push, pop;

    assign o_ready = (r_count != FULL);
    assign o_valid = (r_count != '0);
    assign o_pkt = r_mem[r_rd_ptr];
    assign push = i_valid && o_ready;
    assign pop = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wr_ptr] <= i_pkt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            if (push) r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
            if (pop) r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
            if (push && !pop) r_count <= r_count + 1'b1;
            else if (pop && !push) r_count <= r_count - 1'b1;
        end
    end

endmodule

// ----- rtl/core/mpct_back.sv -----
// Cursor tracker: clamps the cursor, classifies events, holds the result register.
`timescale 1ns / 1ps

module mpct_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  mpct_pkg::t_cfg                    i_cfg,
    input  logic                              i_pkt_valid,
    input  mpct_pkg::t_packet                 i_pkt,
    output logic                              o_pkt_ready,
    output logic                              o_valid,
    output logic [mpct_pkg::M_TDATA_W-1:0]    o_data,
    output logic [mpct_pkg::M_TUSER_W-1:0]    o_user,
    input  logic                              i_ready
);
    import mpct_pkg::*;

    localparam logic signed [14:0] POS_MAX = 15'sd4095;

    function automatic logic [11:0] clamp_axis(
        input logic [11:0] pos,
        input logic signed [9:0] delta,
        input logic [12:0] screen,
        input logic [8:0] cursor
    );
        logic signed [14:0] v;
        logic signed [14:0] scr;
        logic signed [14:0] cur;
        logic [11:0] res;
        scr = signed'({2'b00, screen});
        cur = signed'({6'b000000, cursor});
        v = signed'({3'b000, pos}) + 15'(delta);
        if (v + cur > scr) v = scr - cur;
        if (v < 0) res = '0;
        else if (v > POS_MAX) res = POS_MAX[11:0];
        else res = v[11:0];
        return res;
    endfunction

    logic [11:0] r_pos_x, n_pos_x, r_pos_y, n_pos_y;
    logic r_left_held, n_left_held, r_right_held, n_right_held;
    logic r_valid;
    logic [M_TDATA_W-1:0] r_data, n_data;
    logic [M_TUSER_W-1:0] r_user;
    t_event ev;
    logic pop, lb, rb, mb, moved;
    logic signed [9:0] neg_dy;

    assign o_pkt_ready = !r_valid || i_ready;
    assign pop = i_pkt_valid && o_pkt_ready;
    assign o_valid = r_valid;
    assign o_data = r_data;
    assign o_user = r_user;

    assign lb = i_pkt.first_byte[0];
    assign rb = i_pkt.first_byte[1];
    assign mb = i_pkt.first_byte[2];
    assign moved = (i_pkt.delta_x != '0) || (i_pkt.delta_y != '0);
    assign neg_dy = -(10'(i_pkt.delta_y));

    always_comb begin
        n_pos_x = clamp_axis(r_pos_x, 10'(i_pkt.delta_x), i_cfg.screen_width,
                             i_cfg.cursor_width);
        n_pos_y = clamp_axis(r_pos_y, neg_dy, i_cfg.screen_height, i_cfg.cursor_height);
    end

    // Classify from button bits and held flags
    always_comb begin
        n_left_held = r_left_held;
        n_right_held = r_right_held;
        if (lb && !rb && !mb) begin
            n_left_held = 1'b1;
            ev = EV_LPRESS;
        end else if (!lb && rb && !mb) begin
            n_right_held = 1'b1;
            ev = EV_RPRESS;
        end else if (!lb && !rb && !mb && !moved) begin
            if (r_left_held) begin
                n_left_held = 1'b0;
                ev = EV_LRELEASE;
            end else if (r_right_held) begin
                n_right_held = 1'b0;
                ev = EV_RRELEASE;
            end else begin
                ev = EV_OTHER;
            end
        end else if (moved) begin
            ev = EV_MOVE;
        end else begin
            n_left_held = 1'b0;
            n_right_held = 1'b0;
            ev = EV_OTHER;
        end
    end

    assign n_data = {1'b0, n_pos_y, n_pos_x, i_pkt.delta_y, i_pkt.delta_x,
                     i_pkt.first_byte[7:6], mb, rb, lb};

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_data <= n_data;
            r_user <= ev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pos_x <= '0;
            r_pos_y <= '0;
            r_left_held <= 1'b0;
            r_right_held <= 1'b0;
        end else begin
            if (pop) begin
                r_valid <= 1'b1;
                r_pos_x <= n_pos_x;
                r_pos_y <= n_pos_y;
                r_left_held <= n_left_held;
                r_right_held <= n_right_held;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

// ----- rtl/core/mouse_packet_cursor_tracker.sv -----
// Top level of the mouse packet cursor tracker.
`timescale 1ns / 1ps

// Usage:
//   Slave stream (s_*) takes raw mouse bytes, one request per byte. Bytes
//   are framed into three-byte packets; a byte in the first slot whose sync
//   bit (bit 3) is clear is dropped without a result.
//   Master stream (m_*) gives one result request per completed packet:
//   buttons, overflow flags, extended deltas, clamped cursor position in
//   tdata and the event code in tuser.
//   Config channel (i_cfg_*) writes screen and cursor sizes; it is always
//   ready. Write only while no packet is in flight.
// Timing:
//   One byte accepted per cycle while the packet queue is not full. The result
//   of a packet shows on m_tvalid after its third byte is accepted and has
//   passed through the packet queue and then the tracker's result register.
//   The rate is set by the packet queue: the tracker drains one packet per
//   cycle while the master side takes results.
// Reset: framer back to the first slot, queue empty, cursor at 0,0, held
//   flags clear, sizes back to 1024x768 screen and 16x16 cursor.
// Stall: when m_tready is low the result holds; further packets fill the
//   queue, and once it is full s_tready drops until the result is taken.
module mouse_packet_cursor_tracker #(
    parameter int QUEUE_DEPTH = mpct_pkg::MPCT_QUEUE_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // tdata: rx_byte[7:0]
    input  logic [mpct_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // tdata: btn_left[0], btn_right[1], btn_middle[2], x_overflow[3],
    //        y_overflow[4], delta_x[13:5], delta_y[22:14], cursor_x[34:23],
    //        cursor_y[46:35], zero pad[47]
    output logic [mpct_pkg::M_TDATA_W-1:0]    m_tdata,
    // tuser: event_code[2:0]
    output logic [mpct_pkg::M_TUSER_W-1:0]    m_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [mpct_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mpct_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import mpct_pkg::*;

    t_cfg r_cfg;
    logic w_pkt_valid, w_pkt_ready, w_q_valid, w_q_ready;
    t_packet w_pkt, w_q_pkt;

    // Config registers: take every write, drop the upper bits of the narrow ones.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.screen_width <= SCREEN_WIDTH_RST;
            r_cfg.screen_height <= SCREEN_HEIGHT_RST;
            r_cfg.cursor_width <= CURSOR_WIDTH_RST;
            r_cfg.cursor_height <= CURSOR_HEIGHT_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_SCREEN_WIDTH: r_cfg.screen_width <= i_cfg_data;
                CFG_SCREEN_HEIGHT: r_cfg.screen_height <= i_cfg_data;
                CFG_CURSOR_WIDTH: r_cfg.cursor_width <= i_cfg_data[8:0];
                CFG_CURSOR_HEIGHT: r_cfg.cursor_height <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // Front: frame bytes into packets.
    mpct_front u_front (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(s_tvalid),
        .i_byte(s_tdata),
        .o_ready(s_tready),
        .o_pkt_valid(w_pkt_valid),
        .o_pkt(w_pkt),
        .i_pkt_ready(w_pkt_ready)
    );

    // Queue: decouple framing from tracking.
    mpct_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(w_pkt_valid),
        .i_pkt(w_pkt),
        .o_ready(w_pkt_ready),
        .o_valid(w_q_valid),
        .o_pkt(w_q_pkt),
        .i_ready(w_q_ready)
    );

    // Back: move and clamp the cursor, classify, register the result.
    mpct_back u_back (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg(r_cfg),
        .i_pkt_valid(w_q_valid),
        .i_pkt(w_q_pkt),
        .o_pkt_ready(w_q_ready),
        .o_valid(m_tvalid),
        .o_data(m_tdata),
        .o_user(m_tuser),
        .i_ready(m_tready)
    );

    // A framed packet always carries the sync bit in its first byte.
    a_pkt_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pkt_valid && w_pkt_ready) |-> w_pkt.first_byte[SYNC_BIT])
        else $error("packet pushed without sync bit");

    // A queued packet moves to the result register whenever it is free.
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_q_valid && (!m_tvalid || m_tready)) |=> m_tvalid)
        else $error("queued packet not drained");

    // Back-pressure on the byte stream only comes from a queue holding packets.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_tready |-> w_q_valid)
        else $error("byte stream stalled with empty queue");

endmodule
